FILE: sv/pbpc_pkg.sv
// shared constants, types and codes of the page buffer pin cache
package pbpc_pkg;

    localparam int SLOTS      = 64;
    localparam int PAGE_BYTES = 8192;
    localparam int PIN_BITS   = 8;

    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int TAG_PAGE_W = 19;
    localparam int SEG_W      = 32;
    localparam int OFF_W      = 32;
    localparam int TLEN_W     = 16;
    localparam int SIDX_W     = 6;
    localparam int SLOT_OUT_W = 6;
    localparam int POFF_W     = 13;
    localparam int CMD_W      = 2;

    localparam int IN_PAY_W   = SEG_W + OFF_W + TLEN_W + SIDX_W;
    localparam int IN_DATA_W  = ((IN_PAY_W + 7) / 8) * 8;

    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_UNPIN  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ALL_PINNED = 3'd1,
        ST_BAD_UNPIN  = 3'd2,
        ST_OVERRUN    = 3'd3,
        ST_PIN_FULL   = 3'd4,
        ST_RESERVED   = 3'd5
    } t_status;

    typedef enum logic {
        PRB_MATCH = 1'b0,
        PRB_FREE  = 1'b1
    } t_probe;

    typedef struct packed {
        logic [SEG_W-1:0]      seg;
        logic [TAG_PAGE_W-1:0] page;
        logic                  dirty;
        logic [PIN_BITS-1:0]   pin;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_ram_wr;

    // lowest bit first: slot, tuple_offset, hit, fill, writeback, victim seg, victim page, status
    typedef struct packed {
        t_status               status;
        logic [TAG_PAGE_W-1:0] vpage;
        logic [SEG_W-1:0]      vseg;
        logic                  wb;
        logic                  fill;
        logic                  hit;
        logic [POFF_W-1:0]     poff;
        logic [SLOT_OUT_W-1:0] slot;
    } t_result;

    localparam int OUT_PAY_W  = $bits(t_result);
    localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

endpackage

FILE: sv/page_buffer_pin_cache.sv
// top level of the page buffer pin cache with output register
//
// Input channel (i_s_*): one word per request. tuser carries the command
// (read/pin, append, unpin); tdata carries segment, byte offset, tuple
// length and slot index. Output channel (o_m_*): one result word per request
// with slot, page offset, hit/fill/write-back flags, victim tags and status.
// Sequence: a read or append runs a match scan over the slots (through the
// tag memory's registered read port) and, on a miss, a round-robin probe
// for an unpinned slot, then one update step that writes the slot and
// builds the result. A hit ends the match scan and skips the probe; unpin
// reads its slot, waits for the data and updates it; a reserved segment and
// unknown commands go straight to the result. One request is in work at a time.
// Reset clears the sequencer, the probe pointer and every slot's valid bit,
// so all slots read as unused at once; no clearing pass is needed.
// A finished result waits in the output register; a new request is taken
// meanwhile and runs until it too needs the output register.
module page_buffer_pin_cache import pbpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // segment, byte_offset, tuple_length, slot_index
    input  logic [CMD_W-1:0]      i_s_tuser,   // cmd
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // slot, tuple_offset, hit, fill_request,
                                               // writeback_request, victim_segment,
                                               // victim_page, status
);

    logic              out_free;
    logic              done;
    t_result           res;
    t_result           r_m_data;
    logic              r_m_valid;
    logic [SLOT_W-1:0] rd_addr;
    t_ram_wr           wr;
    t_entry            rd_data;

    assign out_free   = !r_m_valid || i_m_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_m_data);

    pbpc_tag_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

    pbpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_seg      (i_s_tdata[31:0]),
        .i_off      (i_s_tdata[63:32]),
        .i_tlen     (i_s_tdata[79:64]),
        .i_sidx     (i_s_tdata[85:80]),
        .i_out_free (out_free),
        .o_done     (done),
        .o_res      (res),
        .o_rd_addr  (rd_addr),
        .o_wr       (wr),
        .i_rd_data  (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (done) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_m_data <= res;
        end
    end

endmodule

FILE: sv/pbpc_tag_ram.sv
// slot tag memory with per-slot valid bits and registered read
module pbpc_tag_ram import pbpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_rd_addr,
    input  t_ram_wr           i_wr,
    output t_entry            o_rd_data
);

    t_entry            r_mem [SLOTS];
    t_entry            r_rd_data;
    logic [SLOTS-1:0]  r_valid;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // never-written slot reads as empty
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: sv/pbpc_cmp.sv
// shared slot test unit: tag match or free-slot check
module pbpc_cmp import pbpc_pkg::*; (
    input  t_probe                i_mode,
    input  t_entry                i_entry,
    input  logic [SEG_W-1:0]      i_seg,
    input  logic [TAG_PAGE_W-1:0] i_page,
    output logic                  o_hit
);

    always_comb begin
        case (i_mode)
            PRB_MATCH: o_hit = (i_entry.seg != '0) && (i_entry.seg == i_seg)
                               && (i_entry.page == i_page);
            PRB_FREE:  o_hit = (i_entry.pin == '0);
            default:   o_hit = 1'b0;
        endcase
    end

endmodule

FILE: sv/pbpc_ctrl.sv
// sequencer: match scan, round-robin victim probe, unpin slot read and slot update
module pbpc_ctrl import pbpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SEG_W-1:0]  i_seg,
    input  logic [OFF_W-1:0]  i_off,
    input  logic [TLEN_W-1:0] i_tlen,
    input  logic [SIDX_W-1:0] i_sidx,
    input  logic              i_out_free,
    output logic              o_done,
    output t_result           o_res,
    output logic [SLOT_W-1:0] o_rd_addr,
    output t_ram_wr           o_wr,
    input  t_entry            i_rd_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MSCAN = 7'b0000010,
        S_PSCAN = 7'b0000100,
        S_SREAD = 7'b0001000,
        S_SWAIT = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [CMD_W-1:0]      r_cmd, n_cmd;
    logic [SEG_W-1:0]      r_seg, n_seg;
    logic [TAG_PAGE_W-1:0] r_page, n_page;
    logic [OFF_W-1:0]      r_off, n_off;
    logic [TLEN_W-1:0]     r_tlen, n_tlen;
    logic [SIDX_W-1:0]     r_sidx, n_sidx;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [SLOT_W-1:0]     r_vp, n_vp;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_hit, n_hit;
    t_entry                r_ent, n_ent;
    t_result               r_res, n_res;
    logic                  r_q_vld;
    logic [SLOT_W-1:0]     r_q_addr;

    logic                  issue;
    logic                  cmp_hit;
    logic                  scan_end;
    logic                  overrun;
    logic [OFF_W-1:0]      in_shift;
    logic [OFF_W-1:0]      poff_full;
    t_probe                mode;

    assign mode       = (r_state == S_PSCAN) ? PRB_FREE : PRB_MATCH;
    assign in_shift   = i_off >> PAGE_SHIFT;
    assign poff_full  = r_off & OFF_W'(PAGE_BYTES - 1);
    assign overrun    = ({1'b0, poff_full} + (OFF_W + 1)'(r_tlen)) > (OFF_W + 1)'(PAGE_BYTES);
    assign scan_end   = (r_cnt == CNT_W'(SLOTS)) && r_q_vld && !cmp_hit;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_res      = r_res;

    pbpc_cmp u_cmp (
        .i_mode  (mode),
        .i_entry (i_rd_data),
        .i_seg   (r_seg),
        .i_page  (r_page),
        .o_hit   (cmp_hit)
    );

    always_comb begin
        issue     = 1'b0;
        o_rd_addr = r_cnt[SLOT_W-1:0];
        case (r_state)
            S_MSCAN: begin
                issue     = (r_cnt < CNT_W'(SLOTS));
                o_rd_addr = r_cnt[SLOT_W-1:0];
            end
            S_PSCAN: begin
                issue     = (r_cnt < CNT_W'(SLOTS));
                o_rd_addr = r_vp + r_cnt[SLOT_W-1:0];
            end
            S_SREAD: begin
                issue     = 1'b1;
                o_rd_addr = SLOT_W'(r_sidx);
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_seg   = r_seg;
        n_page  = r_page;
        n_off   = r_off;
        n_tlen  = r_tlen;
        n_sidx  = r_sidx;
        n_cnt   = r_cnt;
        n_vp    = r_vp;
        n_slot  = r_slot;
        n_hit   = r_hit;
        n_ent   = r_ent;
        n_res   = r_res;
        o_done  = 1'b0;
        o_wr    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd  = i_cmd;
                    n_seg  = i_seg;
                    n_page = in_shift[TAG_PAGE_W-1:0];
                    n_off  = i_off;
                    n_tlen = i_tlen;
                    n_sidx = i_sidx;
                    n_cnt  = '0;
                    n_res  = '0;
                    case (i_cmd)
                        CMD_UNPIN: begin
                            n_res.slot = SLOT_OUT_W'(i_sidx);
                            if (32'(i_sidx) >= SLOTS) begin
                                n_res.status = ST_BAD_UNPIN;
                                n_state      = S_FIN;
                            end else begin
                                n_state = S_SREAD;
                            end
                        end
                        CMD_READ, CMD_APPEND: begin
                            if (i_seg == '0) begin
                                n_res.status = ST_RESERVED;
                                n_state      = S_FIN;
                            end else begin
                                n_state = S_MSCAN;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_MSCAN: begin
                if (issue) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (r_q_vld && cmp_hit) begin
                    n_ent   = i_rd_data;
                    n_slot  = r_q_addr;
                    n_hit   = 1'b1;
                    n_state = S_UPD;
                end else if (scan_end) begin
                    n_cnt   = '0;
                    n_state = S_PSCAN;
                end
            end
            S_PSCAN: begin
                if (issue) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (r_q_vld && cmp_hit) begin
                    n_ent   = i_rd_data;
                    n_slot  = r_q_addr;
                    n_hit   = 1'b0;
                    n_state = S_UPD;
                end else if (scan_end) begin
                    n_res        = '0;
                    n_res.status = ST_ALL_PINNED;
                    n_state      = S_FIN;
                end
            end
            S_SREAD: begin
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                n_ent   = i_rd_data;
                n_slot  = SLOT_W'(r_sidx);
                n_state = S_UPD;
            end
            S_UPD: begin
                n_res   = '0;
                n_state = S_FIN;
                o_wr.addr = r_slot;
                o_wr.data = r_ent;
                case (r_cmd)
                    CMD_UNPIN: begin
                        n_res.slot = SLOT_OUT_W'(r_sidx);
                        if (r_ent.pin == '0) begin
                            n_res.status = ST_BAD_UNPIN;
                        end else begin
                            o_wr.en       = 1'b1;
                            o_wr.data.pin = r_ent.pin - PIN_BITS'(1);
                        end
                    end
                    CMD_READ, CMD_APPEND: begin
                        if (r_hit && r_cmd == CMD_READ && r_ent.pin == PIN_MAX) begin
                            n_res.status = ST_PIN_FULL;
                        end else begin
                            n_res.slot = SLOT_OUT_W'(r_slot);
                            n_res.poff = POFF_W'(poff_full);
                            o_wr.en    = 1'b1;
                            if (r_hit) begin
                                n_res.hit = 1'b1;
                                if (r_cmd == CMD_READ) begin
                                    o_wr.data.pin = r_ent.pin + PIN_BITS'(1);
                                end
                            end else begin
                                n_res.fill = 1'b1;
                                if (r_ent.seg != '0 && r_ent.dirty) begin
                                    n_res.wb    = 1'b1;
                                    n_res.vseg  = r_ent.seg;
                                    n_res.vpage = r_ent.page;
                                end
                                o_wr.data.seg  = r_seg;
                                o_wr.data.page = r_page;
                                o_wr.data.dirty = 1'b0;
                                o_wr.data.pin  = (r_cmd == CMD_READ) ? PIN_BITS'(1) : '0;
                                n_vp = (32'(r_slot) == SLOTS - 1) ? '0
                                                                  : r_slot + SLOT_W'(1);
                            end
                            if (r_cmd == CMD_APPEND) begin
                                o_wr.data.dirty = 1'b1;
                                if (overrun) begin
                                    n_res.status = ST_OVERRUN;
                                end
                            end
                        end
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_vp    <= '0;
            r_q_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_vp    <= n_vp;
            r_q_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_seg    <= n_seg;
        r_page   <= n_page;
        r_off    <= n_off;
        r_tlen   <= n_tlen;
        r_sidx   <= n_sidx;
        r_slot   <= n_slot;
        r_hit    <= n_hit;
        r_ent    <= n_ent;
        r_res    <= n_res;
        r_q_addr <= o_rd_addr;
    end

    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> i_out_free)
        else $error("result handed over while output register busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("accepted a second word without working the first");

    a_wr_only_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> (r_state == S_UPD))
        else $error("tag write outside update step");

    a_miss_pin_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.en && !r_hit && r_cmd == CMD_READ) |-> (o_wr.data.pin == PIN_BITS'(1)))
        else $error("refilled slot not pinned once");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SLOTS))
        else $error("scan counter past slot count");

endmodule
